FILE: hdl/stsc_pkg.sv
package stsc_pkg;

	// configuration port
	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 4;

	localparam logic [CFG_INDEX_W-1:0] CFG_TICK_DIVIDE = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] CFG_HAZARD_HOLD = 1'b1;

	localparam logic [CFG_DATA_W-1:0] TICK_DIVIDE_RESET = 4'd4;
	localparam logic [CFG_DATA_W-1:0] HAZARD_HOLD_RESET = 4'd4;

	// lamp constants
	localparam logic [7:0] LAMPS_ALL_ON  = 8'hFF;
	localparam logic [7:0] LAMPS_ALL_OFF = 8'h00;
	localparam logic [3:0] NIBBLE_ON     = 4'hF;
	localparam logic [3:0] NIBBLE_OFF    = 4'h0;
	localparam logic [3:0] RIGHT_CHASE_START = 4'b1000;
	localparam logic [3:0] LEFT_CHASE_START  = 4'b0001;

	// button flags
	typedef struct packed {
		logic left_held;
		logic right_held;
		logic brake_held;
		logic left_active;
		logic right_active;
		logic brake_active;
		logic hazard_active;
	} btn_state_t;

	// lamp sequencing state
	typedef struct packed {
		logic [7:0] lamp_byte;
		logic [1:0] left_step;
		logic [1:0] right_step;
		logic       hazard_phase_on;
		logic [3:0] hazard_count;
	} lamp_state_t;

endpackage

FILE: hdl/sequential_turn_signal_controller.sv
// Sequential turn signal and brake lamp controller.
// Input channel: one transaction per button tick carrying left_level,
// right_level and brake_level (active high), handshaked by in_valid/in_stall.
// Output channel: one transaction per tick carrying the lamp byte
// lamp_pattern (bits 7..4 left lamps, bits 3..0 right lamps), out_valid/out_stall.
// Configuration: cfg_write with cfg_index 0 sets tick_divide (ticks per lamp
// step), index 1 sets hazard_hold (extra steps per hazard blink phase);
// write only while no tick is in flight.
// A tick accepted at an edge is registered in the input register, evaluated through
// the button and lamp logic, and written to the result register when it can advance.
// Throughput: one tick per cycle while out_stall is low; the button and lamp state
// update is combinational logic between the input register and the result register.
// A result waiting under out_stall does not block the input register, so one
// more tick is taken; the input stalls only when that tick cannot move on.
// Reset clears all lamp and button state, loads tick_divide and hazard_hold
// with 4, and empties both registers.
module sequential_turn_signal_controller (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_write,
	input  logic [stsc_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [stsc_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             left_level,
	input  logic                             right_level,
	input  logic                             brake_level,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [7:0]                       lamp_pattern
);
	import stsc_pkg::*;

	logic                  valid_s1;
	logic                  left_s1;
	logic                  right_s1;
	logic                  brake_s1;
	logic                  out_valid_q;
	logic [7:0]            lamp_pattern_q;
	logic [CFG_DATA_W-1:0] tick_divide_q;
	logic [CFG_DATA_W-1:0] hazard_hold_q;
	logic [3:0]            tick_count_q;
	btn_state_t            btn_q;
	btn_state_t            btn_nxt;
	lamp_state_t           lamp_q;
	lamp_state_t           lamp_nxt;
	logic [4:0]            tick_next;
	logic                  step_due;
	logic                  advance;

	// handshake
	assign advance   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !advance;
	assign out_valid = out_valid_q;
	assign lamp_pattern = lamp_pattern_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_divide_q <= TICK_DIVIDE_RESET;
			hazard_hold_q <= HAZARD_HOLD_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_TICK_DIVIDE: tick_divide_q <= cfg_data;
				CFG_HAZARD_HOLD: hazard_hold_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			left_s1  <= left_level;
			right_s1 <= right_level;
			brake_s1 <= brake_level;
		end
	end

	// button evaluation and lamp step
	stsc_button_eval u_button_eval (
		.cur         (btn_q),
		.left_level  (left_s1),
		.right_level (right_s1),
		.brake_level (brake_s1),
		.nxt         (btn_nxt)
	);

	stsc_lamp_step u_lamp_step (
		.cur         (lamp_q),
		.btn         (btn_nxt),
		.hazard_hold (hazard_hold_q),
		.nxt         (lamp_nxt)
	);

	// tick divider
	assign tick_next = {1'b0, tick_count_q} + 5'd1;
	assign step_due  = tick_next >= {1'b0, tick_divide_q};

	// state update for each transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			btn_q        <= '0;
			lamp_q       <= '0;
			tick_count_q <= 4'd0;
		end else if (advance) begin
			btn_q <= btn_nxt;
			if (step_due) begin
				lamp_q       <= lamp_nxt;
				tick_count_q <= 4'd0;
			end else begin
				tick_count_q <= tick_next[3:0];
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			lamp_pattern_q <= step_due ? lamp_nxt.lamp_byte : lamp_q.lamp_byte;
		end
	end

	// checks
	assert property (@(posedge clk) disable iff (!arst_n)
		!(btn_q.left_active && btn_q.right_active))
		else $error("left and right signals active together");

	assert property (@(posedge clk) disable iff (!arst_n)
		tick_count_q != 4'hF)
		else $error("tick count ran past its period");

	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_q && out_stall))
		else $error("input stalled with room in the pipeline");

endmodule

FILE: hdl/stsc_button_eval.sv
module stsc_button_eval (
	input  stsc_pkg::btn_state_t cur,
	input  logic                 left_level,
	input  logic                 right_level,
	input  logic                 brake_level,
	output stsc_pkg::btn_state_t nxt
);
	import stsc_pkg::*;

	// press and release handling, left then right then brake
	always_comb begin
		nxt = cur;
		if ((!cur.left_held || !cur.right_held) && left_level && right_level) begin
			// both sides pressed together toggle hazard mode
			nxt.hazard_active = !cur.hazard_active;
			nxt.left_held     = 1'b1;
			nxt.right_held    = 1'b1;
			nxt.brake_held    = 1'b0;
		end else if (!cur.hazard_active) begin
			if (cur.left_held && !left_level) begin
				nxt.left_held = 1'b0;
			end else if (!cur.left_held && left_level) begin
				nxt.left_active  = !cur.left_active;
				nxt.left_held    = 1'b1;
				nxt.right_active = 1'b0;
			end
			if (nxt.right_held && !right_level) begin
				nxt.right_held = 1'b0;
			end else if (!nxt.right_held && right_level) begin
				nxt.right_active = !nxt.right_active;
				nxt.right_held   = 1'b1;
				nxt.left_active  = 1'b0;
			end
			if (cur.brake_held && !brake_level) begin
				nxt.brake_held = 1'b0;
			end else if (!cur.brake_held && brake_level) begin
				nxt.brake_active = !cur.brake_active;
				nxt.brake_held   = 1'b1;
			end
		end else begin
			// hazard mode only tracks releases
			if (cur.left_held && !left_level) begin
				nxt.left_held = 1'b0;
			end
			if (cur.right_held && !right_level) begin
				nxt.right_held = 1'b0;
			end
		end
	end

endmodule

FILE: hdl/stsc_lamp_step.sv
module stsc_lamp_step (
	input  stsc_pkg::lamp_state_t cur,
	input  stsc_pkg::btn_state_t  btn,
	input  logic [3:0]            hazard_hold,
	output stsc_pkg::lamp_state_t nxt
);
	import stsc_pkg::*;

	logic [3:0] right_nibble;
	logic [3:0] left_nibble;

	// one lamp update step
	always_comb begin
		nxt          = cur;
		right_nibble = cur.lamp_byte[3:0];
		left_nibble  = cur.lamp_byte[7:4];
		if (btn.hazard_active) begin
			nxt.lamp_byte = cur.hazard_phase_on ? LAMPS_ALL_ON : LAMPS_ALL_OFF;
			if (cur.hazard_count < hazard_hold) begin
				nxt.hazard_count = cur.hazard_count + 4'd1;
			end else begin
				nxt.hazard_count    = 4'd0;
				nxt.hazard_phase_on = !cur.hazard_phase_on;
			end
		end else begin
			// right side chases downward from bit 3, or shows the brake
			if (btn.right_active || (cur.right_step != 2'd0)) begin
				right_nibble   = RIGHT_CHASE_START >> cur.right_step;
				nxt.right_step = cur.right_step + 2'd1;
			end else begin
				right_nibble   = btn.brake_active ? NIBBLE_ON : NIBBLE_OFF;
				nxt.right_step = 2'd0;
			end
			// left side chases upward from bit 4, or shows the brake
			if (btn.left_active || (cur.left_step != 2'd0)) begin
				left_nibble   = LEFT_CHASE_START << cur.left_step;
				nxt.left_step = cur.left_step + 2'd1;
			end else begin
				left_nibble   = btn.brake_active ? NIBBLE_ON : NIBBLE_OFF;
				nxt.left_step = 2'd0;
			end
			nxt.lamp_byte = {left_nibble, right_nibble};
		end
	end

endmodule
